// File: rtl/h27_pkg.sv
`default_nettype none

package h27_pkg;

  localparam int NODES   = 27;
  localparam int DIMS    = 3;
  localparam int FACTORS = 3;
  localparam int IN_W    = 18;
  localparam int NODE_W  = 5;
  localparam int SHAPE_W = 18;
  localparam int DERIV_W = 19;

  localparam logic [NODE_W-1:0] LAST_NODE = NODE_W'(NODES - 1);

  // which 1d factor an axis uses: node coordinate -1, +1 or 0
  typedef enum logic [1:0] {
    FAC_NEG = 2'd0,
    FAC_POS = 2'd1,
    FAC_MID = 2'd2
  } fac_t;

  typedef struct packed {
    fac_t xi;
    fac_t eta;
    fac_t zeta;
  } node_sel_t;

  // control that travels with each node through the product pipeline
  typedef struct packed {
    logic              vld;
    logic [NODE_W-1:0] idx;
    logic              last;
  } node_tag_t;

  // factor selection per node: corners, edges, faces, centre
  function automatic node_sel_t node_sel(input logic [NODE_W-1:0] n);
    node_sel_t s;
    unique case (n)
      5'd0:    s = '{FAC_NEG, FAC_NEG, FAC_NEG};
      5'd1:    s = '{FAC_POS, FAC_NEG, FAC_NEG};
      5'd2:    s = '{FAC_POS, FAC_POS, FAC_NEG};
      5'd3:    s = '{FAC_NEG, FAC_POS, FAC_NEG};
      5'd4:    s = '{FAC_NEG, FAC_NEG, FAC_POS};
      5'd5:    s = '{FAC_POS, FAC_NEG, FAC_POS};
      5'd6:    s = '{FAC_POS, FAC_POS, FAC_POS};
      5'd7:    s = '{FAC_NEG, FAC_POS, FAC_POS};
      5'd8:    s = '{FAC_MID, FAC_NEG, FAC_NEG};
      5'd9:    s = '{FAC_POS, FAC_MID, FAC_NEG};
      5'd10:   s = '{FAC_MID, FAC_POS, FAC_NEG};
      5'd11:   s = '{FAC_NEG, FAC_MID, FAC_NEG};
      5'd12:   s = '{FAC_MID, FAC_NEG, FAC_POS};
      5'd13:   s = '{FAC_POS, FAC_MID, FAC_POS};
      5'd14:   s = '{FAC_MID, FAC_POS, FAC_POS};
      5'd15:   s = '{FAC_NEG, FAC_MID, FAC_POS};
      5'd16:   s = '{FAC_NEG, FAC_NEG, FAC_MID};
      5'd17:   s = '{FAC_POS, FAC_NEG, FAC_MID};
      5'd18:   s = '{FAC_POS, FAC_POS, FAC_MID};
      5'd19:   s = '{FAC_NEG, FAC_POS, FAC_MID};
      5'd20:   s = '{FAC_MID, FAC_NEG, FAC_MID};
      5'd21:   s = '{FAC_POS, FAC_MID, FAC_MID};
      5'd22:   s = '{FAC_MID, FAC_POS, FAC_MID};
      5'd23:   s = '{FAC_NEG, FAC_MID, FAC_MID};
      5'd24:   s = '{FAC_MID, FAC_MID, FAC_NEG};
      5'd25:   s = '{FAC_MID, FAC_MID, FAC_POS};
      5'd26:   s = '{FAC_MID, FAC_MID, FAC_MID};
      default: s = '{FAC_NEG, FAC_NEG, FAC_NEG};
    endcase
    return s;
  endfunction

endpackage

`default_nettype wire

// File: rtl/hex27_shape_function_eval.sv
// an item passes the axis pipelines, the pending slot and the node pipeline
// its nodes 0 to 26 leave in order through the single result port, which sets the pace
// the next item is taken while the current one is still emitting nodes
// the receiver cannot stall: each result shows for one cycle with result_valid
// reset (rst, synchronous) clears all valid bits and the node sequencer; busy drops low
`default_nettype none

module hex27_shape_function_eval #(
  parameter int FRAC_BITS = 16
) (
  input  wire logic                                clk,
  input  wire logic                                rst,
  input  wire logic                                start,
  output logic                                     busy,
  input  wire logic signed [h27_pkg::IN_W-1:0]     coord_xi,
  input  wire logic signed [h27_pkg::IN_W-1:0]     coord_eta,
  input  wire logic signed [h27_pkg::IN_W-1:0]     coord_zeta,
  output logic                                     result_valid,
  output logic [h27_pkg::NODE_W-1:0]               node_index,
  output logic signed [h27_pkg::SHAPE_W-1:0]       shape_value,
  output logic signed [h27_pkg::DERIV_W-1:0]       deriv_xi,
  output logic signed [h27_pkg::DERIV_W-1:0]       deriv_eta,
  output logic signed [h27_pkg::DERIV_W-1:0]       deriv_zeta,
  output logic                                     last_node
);

  localparam int FW = FRAC_BITS + 3;

  logic                accept;
  logic                pipe_busy;
  logic                a_vld;
  logic [h27_pkg::DIMS-1:0] axis_occ;
  logic [h27_pkg::DIMS-1:0] axis_vld;
  logic signed [FW-1:0] a_val [h27_pkg::DIMS][h27_pkg::FACTORS];
  logic signed [FW-1:0] a_der [h27_pkg::DIMS][h27_pkg::FACTORS];
  logic signed [FW-1:0] pend_val [h27_pkg::DIMS][h27_pkg::FACTORS];
  logic signed [FW-1:0] pend_der [h27_pkg::DIMS][h27_pkg::FACTORS];
  logic signed [FW-1:0] bank_val [h27_pkg::DIMS][h27_pkg::FACTORS];
  logic signed [FW-1:0] bank_der [h27_pkg::DIMS][h27_pkg::FACTORS];
  logic                pend_vld;
  logic                active;
  logic [h27_pkg::NODE_W-1:0] node_cnt;
  logic                at_last;
  logic                load;
  h27_pkg::node_tag_t  tag_in, tag_out;

  assign accept  = start & ~busy;
  assign busy    = pipe_busy | pend_vld;
  assign at_last = (node_cnt == h27_pkg::LAST_NODE);
  assign load    = pend_vld & (~active | at_last);

  // the three axis pipelines run in lockstep
  assign pipe_busy = |axis_occ;
  assign a_vld     = &axis_vld;

  // per-axis factor pipelines
  h27_axis #(.FRAC_BITS(FRAC_BITS)) u_axis_xi (
    .clk      (clk),
    .rst      (rst),
    .in_vld   (accept),
    .coord    (coord_xi),
    .occupied (axis_occ[0]),
    .out_vld  (axis_vld[0]),
    .val      (a_val[0]),
    .der      (a_der[0])
  );

  h27_axis #(.FRAC_BITS(FRAC_BITS)) u_axis_eta (
    .clk      (clk),
    .rst      (rst),
    .in_vld   (accept),
    .coord    (coord_eta),
    .occupied (axis_occ[1]),
    .out_vld  (axis_vld[1]),
    .val      (a_val[1]),
    .der      (a_der[1])
  );

  h27_axis #(.FRAC_BITS(FRAC_BITS)) u_axis_zeta (
    .clk      (clk),
    .rst      (rst),
    .in_vld   (accept),
    .coord    (coord_zeta),
    .occupied (axis_occ[2]),
    .out_vld  (axis_vld[2]),
    .val      (a_val[2]),
    .der      (a_der[2])
  );

  // pending slot and node sequencer control
  always_ff @(posedge clk) begin
    if (rst) begin
      pend_vld <= 1'b0;
      active   <= 1'b0;
      node_cnt <= '0;
    end else begin
      if (a_vld) begin
        pend_vld <= 1'b1;
      end else if (load) begin
        pend_vld <= 1'b0;
      end
      if (load) begin
        active   <= 1'b1;
        node_cnt <= '0;
      end else if (active && at_last) begin
        active   <= 1'b0;
      end else if (active) begin
        node_cnt <= node_cnt + 1'b1;
      end
    end
  end

  // factor banks: pending item and item being emitted
  always_ff @(posedge clk) begin
    if (a_vld) begin
      pend_val <= a_val;
      pend_der <= a_der;
    end
    if (load) begin
      bank_val <= pend_val;
      bank_der <= pend_der;
    end
  end

  assign tag_in = '{vld: active, idx: node_cnt, last: at_last};

  h27_node #(.FRAC_BITS(FRAC_BITS)) u_node (
    .clk         (clk),
    .rst         (rst),
    .tag_in      (tag_in),
    .val         (bank_val),
    .der         (bank_der),
    .tag_out     (tag_out),
    .shape_value (shape_value),
    .deriv_xi    (deriv_xi),
    .deriv_eta   (deriv_eta),
    .deriv_zeta  (deriv_zeta)
  );

  assign result_valid = tag_out.vld;
  assign node_index   = tag_out.idx;
  assign last_node    = tag_out.last;

endmodule

`default_nettype wire

// File: rtl/h27_axis.sv
`default_nettype none

// one axis: clamp, form the three quadratic factors and their derivatives
module h27_axis #(
  parameter int FRAC_BITS = 16
) (
  input  wire logic                                 clk,
  input  wire logic                                 rst,
  input  wire logic                                 in_vld,
  input  wire logic signed [h27_pkg::IN_W-1:0]      coord,
  output logic                                      occupied,
  output logic                                      out_vld,
  output logic signed [FRAC_BITS+2:0]               val [h27_pkg::FACTORS],
  output logic signed [FRAC_BITS+2:0]               der [h27_pkg::FACTORS]
);

  localparam int XW = FRAC_BITS + 2;
  localparam int FW = FRAC_BITS + 3;
  localparam int CW = (h27_pkg::IN_W > XW) ? h27_pkg::IN_W : XW;
  localparam int PW = 2 * XW + 1;
  localparam int QW = 2 * XW;

  localparam logic signed [CW-1:0] ONE_C  = CW'(1) << FRAC_BITS;
  localparam logic signed [XW:0]   ONE_X  = (XW+1)'(1) << FRAC_BITS;
  localparam logic signed [PW:0]   RND_L  = (PW+1)'(1) << FRAC_BITS;
  localparam logic signed [QW:0]   RND_Q  = (QW+1)'(1) << (FRAC_BITS - 1);
  localparam logic signed [FW-1:0] ONE_F  = FW'(1) << FRAC_BITS;
  localparam logic signed [FW-1:0] HALF_F = FW'(1) << (FRAC_BITS - 1);

  logic                   v1, v2;
  logic signed [XW-1:0]   x1, x2;
  logic signed [PW-1:0]   p_neg, p_pos;
  logic signed [QW-1:0]   p_sq;

  logic signed [CW-1:0]   c_ext, c_clamp;
  logic signed [XW:0]     xm, xp;
  logic signed [PW:0]     r_neg, r_pos;
  logic signed [QW:0]     r_sq;
  logic signed [FW-1:0]   xf;

  // clamp to +-1.0
  assign c_ext   = CW'(coord);
  assign c_clamp = (c_ext > ONE_C) ? ONE_C : ((c_ext < -ONE_C) ? -ONE_C : c_ext);

  // x - 1 and x + 1 for the corner factors
  assign xm = (XW+1)'(x1) - ONE_X;
  assign xp = (XW+1)'(x1) + ONE_X;

  // round to nearest, ties up
  assign r_neg = (PW+1)'(p_neg) + RND_L;
  assign r_pos = (PW+1)'(p_pos) + RND_L;
  assign r_sq  = (QW+1)'(p_sq) + RND_Q;
  assign xf    = FW'(x2);

  assign occupied = v1 | v2 | out_vld;

  // valid bits
  always_ff @(posedge clk) begin
    if (rst) begin
      v1      <= 1'b0;
      v2      <= 1'b0;
      out_vld <= 1'b0;
    end else begin
      v1      <= in_vld;
      v2      <= v1;
      out_vld <= v2;
    end
  end

  // stage 1 clamp, stage 2 products, stage 3 rounding
  always_ff @(posedge clk) begin
    x1     <= XW'(c_clamp);
    x2     <= x1;
    p_neg  <= PW'(x1) * PW'(xm);
    p_pos  <= PW'(x1) * PW'(xp);
    p_sq   <= QW'(x1) * QW'(x1);
    val[0] <= FW'(r_neg >>> (FRAC_BITS + 1));
    val[1] <= FW'(r_pos >>> (FRAC_BITS + 1));
    val[2] <= ONE_F - FW'(r_sq >>> FRAC_BITS);
    der[0] <= xf - HALF_F;
    der[1] <= xf + HALF_F;
    der[2] <= -(xf <<< 1);
  end

endmodule

`default_nettype wire

// File: rtl/h27_node.sv
`default_nettype none

// per-node triple products: select, a*b, round, (ab)*c, round and saturate
module h27_node #(
  parameter int FRAC_BITS = 16
) (
  input  wire logic                                   clk,
  input  wire logic                                   rst,
  input  wire h27_pkg::node_tag_t                     tag_in,
  input  wire logic signed [FRAC_BITS+2:0]            val [h27_pkg::DIMS][h27_pkg::FACTORS],
  input  wire logic signed [FRAC_BITS+2:0]            der [h27_pkg::DIMS][h27_pkg::FACTORS],
  output h27_pkg::node_tag_t                          tag_out,
  output logic signed [h27_pkg::SHAPE_W-1:0]          shape_value,
  output logic signed [h27_pkg::DERIV_W-1:0]          deriv_xi,
  output logic signed [h27_pkg::DERIV_W-1:0]          deriv_eta,
  output logic signed [h27_pkg::DERIV_W-1:0]          deriv_zeta
);

  localparam int FW = FRAC_BITS + 3;
  localparam int MW = 2 * FW;

  localparam logic signed [MW:0] RND   = (MW+1)'(1) << (FRAC_BITS - 1);
  localparam logic signed [MW:0] ONE_R = (MW+1)'(1) << FRAC_BITS;
  localparam logic signed [MW:0] TWO_R = (MW+1)'(1) << (FRAC_BITS + 1);

  h27_pkg::node_tag_t tag1, tag2, tag3, tag4;
  h27_pkg::node_sel_t sel;

  logic signed [FW-1:0] vx1, dx1, vy1, dy1, vz1, dz1;
  logic signed [FW-1:0] vz2, dz2, vz3, dz3;
  logic signed [MW-1:0] m_vv, m_dv, m_vd;
  logic signed [FW-1:0] q_vv, q_dv, q_vd;
  logic signed [MW-1:0] t_s, t_x, t_y, t_z;
  logic signed [MW:0]   r_vv, r_dv, r_vd;
  logic signed [MW:0]   r_s, r_x, r_y, r_z;

  function automatic logic signed [MW:0] sat(input logic signed [MW:0] v,
                                             input logic signed [MW:0] lim);
    logic signed [MW:0] r;
    r = v;
    if (v > lim) begin
      r = lim;
    end else if (v < -lim) begin
      r = -lim;
    end
    return r;
  endfunction

  assign sel = h27_pkg::node_sel(tag_in.idx);

  // rounding of the first and second products
  assign r_vv = (MW+1)'(m_vv) + RND;
  assign r_dv = (MW+1)'(m_dv) + RND;
  assign r_vd = (MW+1)'(m_vd) + RND;
  assign r_s  = ((MW+1)'(t_s) + RND) >>> FRAC_BITS;
  assign r_x  = ((MW+1)'(t_x) + RND) >>> FRAC_BITS;
  assign r_y  = ((MW+1)'(t_y) + RND) >>> FRAC_BITS;
  assign r_z  = ((MW+1)'(t_z) + RND) >>> FRAC_BITS;

  // control pipeline
  always_ff @(posedge clk) begin
    if (rst) begin
      tag1    <= '0;
      tag2    <= '0;
      tag3    <= '0;
      tag4    <= '0;
      tag_out <= '0;
    end else begin
      tag1    <= tag_in;
      tag2    <= tag1;
      tag3    <= tag2;
      tag4    <= tag3;
      tag_out <= tag4;
    end
  end

  // data pipeline
  always_ff @(posedge clk) begin
    // factor selection for this node
    vx1 <= val[0][sel.xi];
    dx1 <= der[0][sel.xi];
    vy1 <= val[1][sel.eta];
    dy1 <= der[1][sel.eta];
    vz1 <= val[2][sel.zeta];
    dz1 <= der[2][sel.zeta];
    // xi times eta
    m_vv <= MW'(vx1) * MW'(vy1);
    m_dv <= MW'(dx1) * MW'(vy1);
    m_vd <= MW'(vx1) * MW'(dy1);
    vz2  <= vz1;
    dz2  <= dz1;
    // round the pair products
    q_vv <= FW'(r_vv >>> FRAC_BITS);
    q_dv <= FW'(r_dv >>> FRAC_BITS);
    q_vd <= FW'(r_vd >>> FRAC_BITS);
    vz3  <= vz2;
    dz3  <= dz2;
    // times zeta
    t_s  <= MW'(q_vv) * MW'(vz3);
    t_x  <= MW'(q_dv) * MW'(vz3);
    t_y  <= MW'(q_vd) * MW'(vz3);
    t_z  <= MW'(q_vv) * MW'(dz3);
    // round, saturate, fit to the result fields
    shape_value <= h27_pkg::SHAPE_W'(sat(r_s, ONE_R));
    deriv_xi    <= h27_pkg::DERIV_W'(sat(r_x, TWO_R));
    deriv_eta   <= h27_pkg::DERIV_W'(sat(r_y, TWO_R));
    deriv_zeta  <= h27_pkg::DERIV_W'(sat(r_z, TWO_R));
  end

endmodule

`default_nettype wire

// File: rtl/h27_chk.sv
`default_nettype none

module h27_chk (
  input wire logic                         clk,
  input wire logic                         rst,
  input wire logic                         start,
  input wire logic                         busy,
  input wire logic                         result_valid,
  input wire logic [h27_pkg::NODE_W-1:0]   node_index,
  input wire logic                         last_node
);

  // reset leaves the block idle with no result on the port
  a_reset_idle: assert property (@(posedge clk) rst |=> !busy && !result_valid)
    else $error("block not idle after reset");

  // a taken item holds off the next one
  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    start && !busy |=> busy)
    else $error("busy did not rise after an item was taken");

  // last flag marks exactly the final node
  a_last_node: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> (last_node == (node_index == h27_pkg::LAST_NODE)))
    else $error("last_node does not match node 26");

  // nodes of one item come in consecutive cycles, in order
  a_node_seq: assert property (@(posedge clk) disable iff (rst)
    result_valid && !last_node |=>
      result_valid && (node_index == $past(node_index) + 1'b1))
    else $error("node sequence broken");

endmodule

bind hex27_shape_function_eval h27_chk u_h27_chk (.*);

`default_nettype wire

// File: dv/tb_top.sv
`default_nettype none

module tb_top;

  localparam int FRAC      = 16;
  localparam int N_RANDOM  = 446;
  localparam int N_TABLE   = 24;
  localparam int TAIL_WAIT = 40;

  typedef logic signed [h27_pkg::IN_W-1:0] coord_t;

  // one node result as the block should emit it
  typedef struct {
    logic [h27_pkg::NODE_W-1:0]         idx;
    logic signed [h27_pkg::SHAPE_W-1:0] shape;
    logic signed [h27_pkg::DERIV_W-1:0] dxi;
    logic signed [h27_pkg::DERIV_W-1:0] deta;
    logic signed [h27_pkg::DERIV_W-1:0] dzeta;
    logic                               last_flag;
  } node_result_t;

  // directed row: coordinates as plain integers, pin_node >= 0 means the point
  // sits on that node, so its shape is 1.0 and every other shape is 0
  typedef struct {
    int x;
    int y;
    int z;
    int pin_node;
  } point_row_t;

  logic                               clk;
  logic                               rst;
  logic                               start;
  logic                               busy;
  coord_t                             coord_xi;
  coord_t                             coord_eta;
  coord_t                             coord_zeta;
  logic                               result_valid;
  logic [h27_pkg::NODE_W-1:0]         node_index;
  logic signed [h27_pkg::SHAPE_W-1:0] shape_value;
  logic signed [h27_pkg::DERIV_W-1:0] deriv_xi;
  logic signed [h27_pkg::DERIV_W-1:0] deriv_eta;
  logic signed [h27_pkg::DERIV_W-1:0] deriv_zeta;
  logic                               last_node;

  node_result_t pending_nodes[$];
  int           mismatches    = 0;
  int           points_sent   = 0;
  int           clamped_sent  = 0;
  int           nodes_checked = 0;

  // factor used per axis for each node: corners, edges, faces, centre
  localparam h27_pkg::node_sel_t NODE_MAP [h27_pkg::NODES] = '{
    '{h27_pkg::FAC_NEG, h27_pkg::FAC_NEG, h27_pkg::FAC_NEG},
    '{h27_pkg::FAC_POS, h27_pkg::FAC_NEG, h27_pkg::FAC_NEG},
    '{h27_pkg::FAC_POS, h27_pkg::FAC_POS, h27_pkg::FAC_NEG},
    '{h27_pkg::FAC_NEG, h27_pkg::FAC_POS, h27_pkg::FAC_NEG},
    '{h27_pkg::FAC_NEG, h27_pkg::FAC_NEG, h27_pkg::FAC_POS},
    '{h27_pkg::FAC_POS, h27_pkg::FAC_NEG, h27_pkg::FAC_POS},
    '{h27_pkg::FAC_POS, h27_pkg::FAC_POS, h27_pkg::FAC_POS},
    '{h27_pkg::FAC_NEG, h27_pkg::FAC_POS, h27_pkg::FAC_POS},
    '{h27_pkg::FAC_MID, h27_pkg::FAC_NEG, h27_pkg::FAC_NEG},
    '{h27_pkg::FAC_POS, h27_pkg::FAC_MID, h27_pkg::FAC_NEG},
    '{h27_pkg::FAC_MID, h27_pkg::FAC_POS, h27_pkg::FAC_NEG},
    '{h27_pkg::FAC_NEG, h27_pkg::FAC_MID, h27_pkg::FAC_NEG},
    '{h27_pkg::FAC_MID, h27_pkg::FAC_NEG, h27_pkg::FAC_POS},
    '{h27_pkg::FAC_POS, h27_pkg::FAC_MID, h27_pkg::FAC_POS},
    '{h27_pkg::FAC_MID, h27_pkg::FAC_POS, h27_pkg::FAC_POS},
    '{h27_pkg::FAC_NEG, h27_pkg::FAC_MID, h27_pkg::FAC_POS},
    '{h27_pkg::FAC_NEG, h27_pkg::FAC_NEG, h27_pkg::FAC_MID},
    '{h27_pkg::FAC_POS, h27_pkg::FAC_NEG, h27_pkg::FAC_MID},
    '{h27_pkg::FAC_POS, h27_pkg::FAC_POS, h27_pkg::FAC_MID},
    '{h27_pkg::FAC_NEG, h27_pkg::FAC_POS, h27_pkg::FAC_MID},
    '{h27_pkg::FAC_MID, h27_pkg::FAC_NEG, h27_pkg::FAC_MID},
    '{h27_pkg::FAC_POS, h27_pkg::FAC_MID, h27_pkg::FAC_MID},
    '{h27_pkg::FAC_MID, h27_pkg::FAC_POS, h27_pkg::FAC_MID},
    '{h27_pkg::FAC_NEG, h27_pkg::FAC_MID, h27_pkg::FAC_MID},
    '{h27_pkg::FAC_MID, h27_pkg::FAC_MID, h27_pkg::FAC_NEG},
    '{h27_pkg::FAC_MID, h27_pkg::FAC_MID, h27_pkg::FAC_POS},
    '{h27_pkg::FAC_MID, h27_pkg::FAC_MID, h27_pkg::FAC_MID}
  };

  // directed points: node positions, clamped inputs, rounding corners
  point_row_t directed_rows [N_TABLE] = '{
    '{-65536, -65536, -65536,  0}, '{ 65536, -65536, -65536,  1},
    '{ 65536,  65536, -65536,  2}, '{-65536,  65536, -65536,  3},
    '{-65536, -65536,  65536,  4}, '{ 65536, -65536,  65536,  5},
    '{ 65536,  65536,  65536,  6}, '{-65536,  65536,  65536,  7},
    '{     0,      0,      0, 26}, '{     0, -65536, -65536,  8},
    '{ 65536,      0, -65536,  9}, '{-65536, -65536,      0, 16},
    '{     0, -65536,      0, 20}, '{     0,      0, -65536, 24},
    '{     0,      0,  65536, 25}, '{     0,  65536,      0, 22},
    '{131071, -131072, 65537,  5}, '{-65537,  98304, -131072, 3},
    '{ 32768, -32768,  32768, -1}, '{     1,     -1,  65535, -1},
    '{-65535,      3,     -2, -1}, '{ 12345, -54321,  40000, -1},
    '{ 32767, -32769,  16384, -1}, '{-32768,  32768,      0, -1}
  };

  hex27_shape_function_eval #(
    .FRAC_BITS(FRAC)
  ) u_dut (
    .clk         (clk),
    .rst         (rst),
    .start       (start),
    .busy        (busy),
    .coord_xi    (coord_xi),
    .coord_eta   (coord_eta),
    .coord_zeta  (coord_zeta),
    .result_valid(result_valid),
    .node_index  (node_index),
    .shape_value (shape_value),
    .deriv_xi    (deriv_xi),
    .deriv_eta   (deriv_eta),
    .deriv_zeta  (deriv_zeta),
    .last_node   (last_node)
  );

  // clock
  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // run limit
  initial begin
    #5000000;
    $display("simulation failed");
    $finish;
  end

  // round to nearest, ties toward plus infinity
  function automatic longint round_shift(input longint v, input int s);
    return (v + (longint'(1) <<< (s - 1))) >>> s;
  endfunction

  function automatic longint fx_mul(input longint a, input longint b);
    return round_shift(a * b, FRAC);
  endfunction

  function automatic longint clip(input longint v, input longint lim);
    if (v > lim) return lim;
    if (v < -lim) return -lim;
    return v;
  endfunction

  // expected 27 node results for one point, queued in emission order
  function automatic void predict_nodes(input coord_t cx, input coord_t cy,
                                        input coord_t cz, input int pin_node);
    longint       one;
    longint       x;
    longint       c [h27_pkg::DIMS];
    longint       lv [h27_pkg::DIMS][h27_pkg::FACTORS];
    longint       dv [h27_pkg::DIMS][h27_pkg::FACTORS];
    longint       s, gx, gy, gz;
    int           a, b, k;
    node_result_t r;
    one  = longint'(1) <<< FRAC;
    c[0] = clip(longint'(cx), one);
    c[1] = clip(longint'(cy), one);
    c[2] = clip(longint'(cz), one);
    // 1d quadratic factors and their derivatives per axis
    for (int d = 0; d < h27_pkg::DIMS; d++) begin
      x = c[d];
      lv[d][int'(h27_pkg::FAC_NEG)] = round_shift(x * (x - one), FRAC + 1);
      lv[d][int'(h27_pkg::FAC_POS)] = round_shift(x * (x + one), FRAC + 1);
      lv[d][int'(h27_pkg::FAC_MID)] = one - fx_mul(x, x);
      dv[d][int'(h27_pkg::FAC_NEG)] = x - one / 2;
      dv[d][int'(h27_pkg::FAC_POS)] = x + one / 2;
      dv[d][int'(h27_pkg::FAC_MID)] = -2 * x;
    end
    // triple products per node, xi times eta first
    for (int n = 0; n < h27_pkg::NODES; n++) begin
      a  = int'(NODE_MAP[n].xi);
      b  = int'(NODE_MAP[n].eta);
      k  = int'(NODE_MAP[n].zeta);
      s  = clip(fx_mul(fx_mul(lv[0][a], lv[1][b]), lv[2][k]), one);
      gx = clip(fx_mul(fx_mul(dv[0][a], lv[1][b]), lv[2][k]), 2 * one);
      gy = clip(fx_mul(fx_mul(lv[0][a], dv[1][b]), lv[2][k]), 2 * one);
      gz = clip(fx_mul(fx_mul(lv[0][a], lv[1][b]), dv[2][k]), 2 * one);
      r.idx       = h27_pkg::NODE_W'(n);
      r.shape     = h27_pkg::SHAPE_W'(s);
      r.dxi       = h27_pkg::DERIV_W'(gx);
      r.deta      = h27_pkg::DERIV_W'(gy);
      r.dzeta     = h27_pkg::DERIV_W'(gz);
      r.last_flag = (n == h27_pkg::NODES - 1);
      // on a node the shape values are known outright
      if (pin_node >= 0)
        r.shape = (n == pin_node) ? h27_pkg::SHAPE_W'(one) : '0;
      pending_nodes.push_back(r);
    end
  endfunction

  task automatic report_mismatch(input string what);
    mismatches++;
    if (mismatches <= 100)
      $display("mismatch at %0t: %s", $time, what);
  endtask

  // sender gap: mostly none or short, a few long
  function automatic int pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 96) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // coordinates: mostly in range, some special values, some raw 18-bit words
  function automatic coord_t rand_coord();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 65)
      return coord_t'(int'($urandom_range(0, 131072)) - 65536);
    if (r < 80) begin
      case ($urandom_range(0, 7))
        0: return coord_t'(0);
        1: return coord_t'(65536);
        2: return coord_t'(-65536);
        3: return coord_t'(32768);
        4: return coord_t'(-32768);
        5: return coord_t'(1);
        6: return coord_t'(-1);
        default: return coord_t'(65535);
      endcase
    end
    return coord_t'($urandom());
  endfunction

  // drive one point, hold until accepted, then queue its node results
  task automatic send_point(input coord_t x, input coord_t y, input coord_t z,
                            input int gap, input int pin_node);
    @(negedge clk);
    if (gap > 0) begin
      start      <= 1'b0;
      coord_xi   <= coord_t'($urandom());
      coord_eta  <= coord_t'($urandom());
      coord_zeta <= coord_t'($urandom());
      repeat (gap) @(negedge clk);
    end
    start      <= 1'b1;
    coord_xi   <= x;
    coord_eta  <= y;
    coord_zeta <= z;
    @(posedge clk);
    while (busy) @(posedge clk);
    predict_nodes(x, y, z, pin_node);
    points_sent++;
    if (x > 65536 || x < -65536 || y > 65536 || y < -65536 ||
        z > 65536 || z < -65536)
      clamped_sent++;
  endtask

  // result checker
  always @(posedge clk) begin
    node_result_t want;
    if (!rst && result_valid) begin
      if (pending_nodes.size() == 0) begin
        report_mismatch($sformatf("unexpected result for node %0d", node_index));
      end else begin
        want = pending_nodes.pop_front();
        nodes_checked++;
        if (node_index !== want.idx)
          report_mismatch($sformatf("node_index got %0d want %0d", node_index, want.idx));
        if (shape_value !== want.shape)
          report_mismatch($sformatf("node %0d shape_value got %0d want %0d",
                                    want.idx, shape_value, want.shape));
        if (deriv_xi !== want.dxi)
          report_mismatch($sformatf("node %0d deriv_xi got %0d want %0d",
                                    want.idx, deriv_xi, want.dxi));
        if (deriv_eta !== want.deta)
          report_mismatch($sformatf("node %0d deriv_eta got %0d want %0d",
                                    want.idx, deriv_eta, want.deta));
        if (deriv_zeta !== want.dzeta)
          report_mismatch($sformatf("node %0d deriv_zeta got %0d want %0d",
                                    want.idx, deriv_zeta, want.dzeta));
        if (last_node !== want.last_flag)
          report_mismatch($sformatf("node %0d last_node got %0b want %0b",
                                    want.idx, last_node, want.last_flag));
      end
    end
  end

  // stimulus
  initial begin
    rst        = 1'b1;
    start      = 1'b0;
    coord_xi   = '0;
    coord_eta  = '0;
    coord_zeta = '0;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // directed table
    for (int i = 0; i < N_TABLE; i++) begin
      send_point(coord_t'(directed_rows[i].x), coord_t'(directed_rows[i].y),
                 coord_t'(directed_rows[i].z), pick_gap(), directed_rows[i].pin_node);
    end

    // random points, with back-to-back stretches
    for (int i = 0; i < N_RANDOM; i++) begin
      send_point(rand_coord(), rand_coord(), rand_coord(),
                 ((i % 60) < 15) ? 0 : pick_gap(), -1);
    end

    @(negedge clk);
    start <= 1'b0;

    // drain, then watch for stray results
    while (pending_nodes.size() != 0) @(posedge clk);
    repeat (TAIL_WAIT) @(posedge clk);

    $display("points driven: %0d (%0d directed, %0d with clamped coordinates)",
             points_sent, N_TABLE, clamped_sent);
    $display("node results compared: %0d, mismatches: %0d", nodes_checked, mismatches);
    if (mismatches == 0 && pending_nodes.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

`default_nettype wire
